// ===== rtl/mcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mcbd_pkg
// shared constants, types and lane arithmetic for the mip chain downsampler
// ----------------------------------------------------------------------------
package mcbd_pkg;

    localparam int MaxWidth  = 2048;
    localparam int MaxLevels = 12;
    localparam int LvlW      = 4;
    localparam int CntW      = 11;
    localparam int SizeW     = 12;
    localparam int AddrW     = 11;
    localparam int ChanW     = 8;
    localparam int PixW      = 32;
    localparam int LaneW     = 9;
    localparam int PsW       = 36;
    localparam int CoordW    = 10;
    localparam int CfgIdxW   = 1;

    typedef logic [CfgIdxW-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_IMAGE_WIDTH  = 1'd0;
    localparam cfg_idx_t CFG_IMAGE_HEIGHT = 1'd1;

    // line memory access
    typedef struct packed {
        logic             we;
        logic             re;
        logic [AddrW-1:0] addr;
        logic [PsW-1:0]   wdata;
    } ram_req_t;

    // one produced pixel
    typedef struct packed {
        logic [LvlW-1:0]   level;
        logic [CoordW-1:0] column;
        logic [CoordW-1:0] row;
        logic [PixW-1:0]   pixel;
        logic              last;
    } result_t;

    // per-channel sum of two pixels into four 9-bit lanes
    function automatic logic [PsW-1:0] pair_sum(input logic [PixW-1:0] a,
                                                 input logic [PixW-1:0] b);
        logic [PsW-1:0] r;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            r[c*LaneW +: LaneW] = {1'b0, a[c*ChanW +: ChanW]} + {1'b0, b[c*ChanW +: ChanW]};
        end
        return r;
    endfunction

    // lane-wise floor((p + q) / 4)
    function automatic logic [PixW-1:0] quad_avg(input logic [PsW-1:0] p,
                                                 input logic [PsW-1:0] q);
        logic [PixW-1:0]    r;
        logic [LaneW:0]     s;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            s = {1'b0, p[c*LaneW +: LaneW]} + {1'b0, q[c*LaneW +: LaneW]};
            r[c*ChanW +: ChanW] = s[LaneW:2];
        end
        return r;
    endfunction

    // zero reads as one, above the max reads as the max
    function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
        logic [SizeW-1:0] r;
        if (v == '0) r = SizeW'(1);
        else if (v > SizeW'(MaxWidth)) r = SizeW'(MaxWidth);
        else r = v;
        return r;
    endfunction

    // start of a source level's line in the packed line memory
    function automatic logic [SizeW-1:0] line_base(input logic [LvlW-1:0] lv);
        return SizeW'(MaxWidth) - (SizeW'(MaxWidth) >> lv);
    endfunction

endpackage

// ===== rtl/mcbd_line_ram.sv =====
// ----------------------------------------------------------------------------
// mcbd_line_ram
// single port line memory of pair sums, registered read
// ----------------------------------------------------------------------------
module mcbd_line_ram (
    input  logic                       clk,
    input  mcbd_pkg::ram_req_t         req,
    output logic [mcbd_pkg::PsW-1:0]   rdata
);
    import mcbd_pkg::*;

    logic [PsW-1:0] mem [MaxWidth];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.addr];
        end
    end

endmodule

// ===== rtl/mcbd_core.sv =====
// ----------------------------------------------------------------------------
// mcbd_core
// level sequencer: counters, hold pixels, line memory access, result buffer
// ----------------------------------------------------------------------------
module mcbd_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mcbd_pkg::SizeW-1:0]    size_w,
    input  logic [mcbd_pkg::SizeW-1:0]    size_h,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mcbd_pkg::PixW-1:0]     in_pixel,
    output mcbd_pkg::ram_req_t            ram_req,
    input  logic [mcbd_pkg::PsW-1:0]      ram_rdata,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mcbd_pkg::result_t             out_word,
    output logic                          idle
);
    import mcbd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LEVEL, S_AVG, S_LAST} state_t;

    state_t            state_reg;
    logic [LvlW-1:0]   lv_reg;
    logic [PixW-1:0]   pix_reg;
    logic [PsW-1:0]    ps_reg;
    logic [CoordW-1:0] col_out_reg;
    logic [CoordW-1:0] row_out_reg;
    result_t           pend_reg;
    logic              pend_valid_reg;
    result_t           out_reg;
    logic              out_valid_reg;
    logic [CntW-1:0]   col_cnt_reg [MaxLevels];
    logic [CntW-1:0]   row_cnt_reg [MaxLevels];
    logic [PixW-1:0]   hold_reg    [MaxLevels-1];

    logic [CntW-1:0]   x, y;
    logic [SizeW-1:0]  wl, hl, nw, nh, idx;
    logic              x_wrap, y_wrap, in_blk, active, top_lvl;
    logic              hold_we, pair_go, line_rd, line_wr, out_free;
    logic              out_load, out_last;
    logic [PsW-1:0]    pr;
    logic [PixW-1:0]   hold_rd;
    logic [PixW-1:0]   avg;

    always_comb
    begin
        x       = col_cnt_reg[lv_reg];
        y       = row_cnt_reg[lv_reg];
        wl      = size_w >> lv_reg;
        hl      = size_h >> lv_reg;
        nw      = wl >> 1;
        nh      = hl >> 1;
        x_wrap  = ({1'b0, x} + SizeW'(1)) >= wl;
        y_wrap  = ({1'b0, y} + SizeW'(1)) >= hl;
        in_blk  = ({1'b0, x} < (nw << 1)) && ({1'b0, y} < (nh << 1));
        top_lvl = lv_reg == LvlW'(MaxLevels - 1);
        active  = !top_lvl && in_blk;
        hold_rd = top_lvl ? '0 : hold_reg[lv_reg];
        idx     = line_base(lv_reg) + {2'b00, x[CntW-1:1]};
        pr      = pair_sum(hold_rd, pix_reg);
        hold_we = active && !x[0];
        pair_go = active && x[0] && !idx[SizeW-1];
        line_wr = pair_go && !y[0];
        line_rd = pair_go && y[0];
        avg     = quad_avg(ram_rdata, ps_reg);
        out_free = !out_valid_reg || !out_stall;
        // pending result moves to the output register
        out_load = ((state_reg == S_AVG) && pend_valid_reg && out_free)
                   || ((state_reg == S_LAST) && out_free);
        out_last = state_reg == S_LAST;
    end

    assign ram_req.we    = (state_reg == S_LEVEL) && line_wr;
    assign ram_req.re    = (state_reg == S_LEVEL) && line_rd;
    assign ram_req.addr  = idx[AddrW-1:0];
    assign ram_req.wdata = pr;

    assign in_stall  = state_reg != S_IDLE;
    assign idle      = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            lv_reg         <= '0;
            for (int i = 0; i < MaxLevels; i++)
            begin
                col_cnt_reg[i] <= '0;
                row_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_reg.level  <= pend_reg.level;
                out_reg.column <= pend_reg.column;
                out_reg.row    <= pend_reg.row;
                out_reg.pixel  <= pend_reg.pixel;
                out_reg.last   <= out_last;
                out_valid_reg  <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        pix_reg   <= in_pixel;
                        lv_reg    <= '0;
                        state_reg <= S_LEVEL;
                    end
                end
                S_LEVEL:
                begin
                    if (x_wrap)
                    begin
                        col_cnt_reg[lv_reg] <= '0;
                        row_cnt_reg[lv_reg] <= y_wrap ? '0 : y + CntW'(1);
                    end
                    else
                    begin
                        col_cnt_reg[lv_reg] <= x + CntW'(1);
                    end
                    if (hold_we)
                    begin
                        hold_reg[lv_reg] <= pix_reg;
                    end
                    if (line_rd)
                    begin
                        ps_reg      <= pr;
                        col_out_reg <= x[CntW-1:1];
                        row_out_reg <= y[CntW-1:1];
                        state_reg   <= S_AVG;
                    end
                    else if (pend_valid_reg)
                    begin
                        state_reg <= S_LAST;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_AVG:
                begin
                    // previous level's result goes out only once we know it is not last
                    if (!pend_valid_reg || out_free)
                    begin
                        pend_reg.level  <= lv_reg + LvlW'(1);
                        pend_reg.column <= col_out_reg;
                        pend_reg.row    <= row_out_reg;
                        pend_reg.pixel  <= avg;
                        pend_reg.last   <= 1'b0;
                        pend_valid_reg  <= 1'b1;
                        pix_reg         <= avg;
                        lv_reg          <= lv_reg + LvlW'(1);
                        state_reg       <= S_LEVEL;
                    end
                end
                S_LAST:
                begin
                    if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/mip_chain_box_downsample.sv =====
// ----------------------------------------------------------------------------
// mip_chain_box_downsample
// streaming 2x2 box filter mip chain builder for rgba8 images
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | red_in green_in blue_in alpha_in
//  out     | output    | out_valid/out_stall| mip_level column row *_out last_of_run
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index cfg_data
//
// a word that completes no level passes from idle through the level state and
// back to idle; each mip level it completes adds a pass through the avg state
// and back to the level state, and a word that completes any ends in the last
// state to hand over the last result; the sequencer uses a single port line memory
// the next word is taken as soon as the sequencer is back in idle, even while
// the output register still holds an untaken result
// reset clears level counters and sets sizes to 256 x 256; line memory and hold
// pixels are not cleared and need no clearing pass
// out_stall only holds the output register; sequencer waits when it needs it
// ----------------------------------------------------------------------------
module mip_chain_box_downsample (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       red_in,
    input  logic [7:0]                       green_in,
    input  logic [7:0]                       blue_in,
    input  logic [7:0]                       alpha_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [3:0]                       mip_level,
    output logic [9:0]                       column,
    output logic [9:0]                       row,
    output logic [7:0]                       red_out,
    output logic [7:0]                       green_out,
    output logic [7:0]                       blue_out,
    output logic [7:0]                       alpha_out,
    output logic                             last_of_run,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  mcbd_pkg::cfg_idx_t               cfg_index,
    input  logic [mcbd_pkg::SizeW-1:0]       cfg_data
);
    import mcbd_pkg::*;

    logic [SizeW-1:0] width_reg;
    logic [SizeW-1:0] height_reg;
    logic             idle;
    ram_req_t         ram_req;
    logic [PsW-1:0]   ram_rdata;
    result_t          out_word;

    // size registers, written only while the sequencer is idle
    assign cfg_ready = idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SizeW'(256);
            height_reg <= SizeW'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    mcbd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .size_w    (clamp_size(width_reg)),
        .size_h    (clamp_size(height_reg)),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_pixel  ({alpha_in, blue_in, green_in, red_in}),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .idle      (idle)
    );

    // pair sums of every source level, packed line after line
    mcbd_line_ram u_line_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign mip_level   = out_word.level;
    assign column      = out_word.column;
    assign row         = out_word.row;
    assign red_out     = out_word.pixel[7:0];
    assign green_out   = out_word.pixel[15:8];
    assign blue_out    = out_word.pixel[23:16];
    assign alpha_out   = out_word.pixel[31:24];
    assign last_of_run = out_word.last;

endmodule

// ===== rtl/mcbd_checker.sv =====
// ----------------------------------------------------------------------------
// mcbd_checker
// port level checks for the mip chain downsampler
// ----------------------------------------------------------------------------
module mcbd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [3:0]                    mip_level,
    input logic [9:0]                    column,
    input logic [9:0]                    row,
    input logic [7:0]                    red_out,
    input logic                          last_of_run,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);
    import mcbd_pkg::*;

    // an accepted word closes the input from the next cycle on
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // sizes are only writable while no word is in flight
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !cfg_ready)
        else $error("config open while busy");

    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mip_level >= 4'd1) && (mip_level <= 4'(MaxLevels - 1)))
        else $error("mip level out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_out)
            && $stable(column) && $stable(row) && $stable(last_of_run))
        else $error("stalled result changed");

    // a non-final result is always followed by more of the same run
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> in_stall || out_valid)
        else $error("run closed without a last result");

endmodule

bind mip_chain_box_downsample mcbd_checker u_mcbd_checker (.*);

// ===== bench/mip_chain_box_downsample_tb.sv =====
// ----------------------------------------------------------------------------
// mip_chain_box_downsample_tb
// self-checking bench for the streaming 2x2 box filter mip chain builder:
// whole level-0 images are streamed in raster order, a behavioral model of
// the level cascade predicts every produced pixel, and each output word is
// compared field by field in order, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module mip_chain_box_downsample_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mcbd_pkg::*;

    localparam int CycleLimit = 4000000;
    // drain wait covering the worst case per word, with margin
    localparam int DrainCycles = 40;
    localparam int ItemTarget = 410;

    // one expected output word
    typedef struct {
        int unsigned level;
        int unsigned column;
        int unsigned row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
    } mip_pixel_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic out_valid;
    logic out_stall;
    logic [3:0] mip_level;
    logic [9:0] column;
    logic [9:0] row;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic last_of_run;
    logic cfg_valid;
    logic cfg_ready;
    cfg_idx_t cfg_index;
    logic [SizeW-1:0] cfg_data;

    mip_chain_box_downsample i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .alpha_in   (alpha_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .mip_level  (mip_level),
        .column     (column),
        .row        (row),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .alpha_out  (alpha_out),
        .last_of_run(last_of_run),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // model state: sizes as written, line of pair sums, hold pixel, raster counters
    logic [SizeW-1:0] width_reg;
    logic [SizeW-1:0] height_reg;
    logic [PsW-1:0]   pair_line [MaxWidth];
    logic [PixW-1:0]  left_hold [MaxLevels];
    int unsigned      col_count [MaxLevels];
    int unsigned      row_count [MaxLevels];

    mip_pixel_t pending_pixels[$];
    int  mismatch_count;
    int  words_sent;
    int  pixels_seen;
    int  deepest_level;
    int  cycle_count;
    bit  no_gaps;       // burst mode: no idling on the input side
    bit  no_stalls;     // burst mode: no stalls on the output side

    // clock and cycle limit
    initial clk = 1'b0;
    always #2ns clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // mostly short gaps, sometimes a long one
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    function automatic logic [7:0] chan(logic [PixW-1:0] p, int c);
        return p[c*8 +: 8];
    endfunction

    // walk one level-0 pixel up the cascade and queue every pixel it finishes
    function automatic void predict_cascade(logic [PixW-1:0] pixel_in);
        int unsigned w0, h0, wl, hl, x, y, base_addr, idx;
        logic [PixW-1:0] pix;
        logic [PsW-1:0]  pr;
        logic [PixW-1:0] avg;
        logic [9:0]      lane_sum;
        mip_pixel_t      made [MaxLevels];
        mip_pixel_t      one;
        int              n;
        bit              produced;
        w0 = (width_reg == 0) ? 1 : (width_reg > MaxWidth) ? MaxWidth : width_reg;
        h0 = (height_reg == 0) ? 1 : (height_reg > MaxWidth) ? MaxWidth : height_reg;
        pix = pixel_in;
        base_addr = 0;
        n = 0;
        for (int lv = 0; lv < MaxLevels; lv++)
        begin
            wl = w0 >> lv;
            hl = h0 >> lv;
            x = col_count[lv];
            y = row_count[lv];
            produced = 1'b0;
            if (x + 1 >= wl)
            begin
                col_count[lv] = 0;
                row_count[lv] = (y + 1 >= hl) ? 0 : y + 1;
            end
            else
                col_count[lv] = x + 1;
            if (lv + 1 < MaxLevels && x < 2 * (wl >> 1) && y < 2 * (hl >> 1))
            begin
                if (x[0] == 1'b0)
                    left_hold[lv] = pix;
                else
                begin
                    for (int c = 0; c < 4; c++)
                        pr[c*9 +: 9] = chan(left_hold[lv], c) + chan(pix, c);
                    idx = base_addr + (x >> 1);
                    if (idx < MaxWidth)
                    begin
                        if (y[0] == 1'b0)
                            pair_line[idx] = pr;
                        else
                        begin
                            for (int c = 0; c < 4; c++)
                            begin
                                lane_sum = pair_line[idx][c*9 +: 9] + pr[c*9 +: 9];
                                avg[c*8 +: 8] = lane_sum[9:2];
                            end
                            one.level  = lv + 1;
                            one.column = x >> 1;
                            one.row    = y >> 1;
                            one.red    = avg[7:0];
                            one.green  = avg[15:8];
                            one.blue   = avg[23:16];
                            one.alpha  = avg[31:24];
                            one.last   = 1'b0;
                            made[n] = one;
                            n++;
                            pix = avg;
                            produced = 1'b1;
                        end
                    end
                end
            end
            base_addr += MaxWidth >> (lv + 1);
            if (!produced) break;
        end
        if (n > 0) made[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_pixels.insert(pending_pixels.size(), made[i]);
    endfunction

    // one level-0 pixel; valid is left high so back-to-back words need no toggle
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        int gap;
        bit taken;
        gap = no_gaps ? 0 : gap_length();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        alpha_in <= a;
        forever
        begin
            #1ns;
            taken = !in_stall;
            @(posedge clk);
            if (taken) break;
            @(negedge clk);
        end
        words_sent++;
        predict_cascade({a, b, g, r});
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // let all expected words drain, then the sequencer finish any silent word
    task automatic wait_idle();
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_register(cfg_idx_t index, logic [SizeW-1:0] value);
        bit taken;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        forever
        begin
            #1ns;
            taken = cfg_ready;
            @(posedge clk);
            if (taken) break;
            @(negedge clk);
        end
        if (index == CFG_IMAGE_WIDTH) width_reg = value;
        else height_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_size(logic [SizeW-1:0] w, logic [SizeW-1:0] h);
        release_input();
        wait_idle();
        write_register(CFG_IMAGE_WIDTH, w);
        write_register(CFG_IMAGE_HEIGHT, h);
    endtask

    function automatic int unsigned used_size(logic [SizeW-1:0] v);
        return (v == 0) ? 1 : (v > MaxWidth) ? MaxWidth : v;
    endfunction

    // a whole image of random pixels at the current size
    task automatic send_random_image();
        int unsigned total;
        total = used_size(width_reg) * used_size(height_reg);
        for (int unsigned i = 0; i < total; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // output side: random stall driven at the falling edge, word taken at the rise
    always
    begin
        bit took;
        mip_pixel_t want;
        int hold_off;
        @(negedge clk);
        hold_off = no_stalls ? 0 : gap_length();
        if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            repeat (hold_off - 1) @(negedge clk);
            @(negedge clk);
        end
        out_stall <= 1'b0;
        #1ns;
        took = out_valid && rst_n;
        if (took)
        begin
            pixels_seen++;
            if (mip_level > deepest_level) deepest_level = mip_level;
            if (pending_pixels.size() == 0)
                report_mismatch("unexpected word, level", mip_level, 0);
            else
            begin
                want = pending_pixels.pop_front();
                if (mip_level != want.level) report_mismatch("mip_level", mip_level, want.level);
                if (column != want.column) report_mismatch("column", column, want.column);
                if (row != want.row) report_mismatch("row", row, want.row);
                if (red_out != want.red) report_mismatch("red_out", red_out, want.red);
                if (green_out != want.green) report_mismatch("green_out", green_out, want.green);
                if (blue_out != want.blue) report_mismatch("blue_out", blue_out, want.blue);
                if (alpha_out != want.alpha) report_mismatch("alpha_out", alpha_out, want.alpha);
                if (last_of_run != want.last) report_mismatch("last_of_run", last_of_run, want.last);
            end
        end
        @(posedge clk);
    end

    // smallest sizes, channel extremes and floor rounding, odd trailing row and column
    task automatic test_directed();
        set_size(SizeW'(0), SizeW'(0));     // zero size is taken as one pixel
        send_pixel(8'h00, 8'hff, 8'h00, 8'hff);
        send_pixel(8'hff, 8'h00, 8'hff, 8'h00);
        set_size(SizeW'(2), SizeW'(2));
        repeat (4) send_pixel(8'hff, 8'hff, 8'hff, 8'hff);
        repeat (4) send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        // sums 3, 2, 1, 1019 check truncation in every lane
        send_pixel(8'h01, 8'h01, 8'h00, 8'hff);
        send_pixel(8'h01, 8'h00, 8'h00, 8'hff);
        send_pixel(8'h01, 8'h01, 8'h01, 8'hff);
        send_pixel(8'h00, 8'h00, 8'h00, 8'hfe);
        set_size(SizeW'(3), SizeW'(3));     // trailing odd row and column are dropped
        for (int i = 0; i < 9; i++)
            send_pixel(8'(i * 29), 8'(255 - i * 31), 8'(i * 7), 8'(128 + i));
    endtask

    // wide flat image: level 1 is a single row and nothing lies above it
    task automatic test_wide_image();
        set_size(SizeW'(16), SizeW'(2));
        send_random_image();
    endtask

    // narrow tall image: level 1 is a single column and nothing lies above it
    task automatic test_tall_image();
        set_size(SizeW'(2), SizeW'(16));
        send_random_image();
    endtask

    // one square image deep enough for four levels, then well-formed images of
    // random small sizes, some back-to-back without a size write
    task automatic test_random_images();
        set_size(SizeW'(16), SizeW'(16));
        send_random_image();
        while (words_sent < ItemTarget)
        begin
            no_gaps   = ($urandom_range(0, 3) == 0);
            no_stalls = ($urandom_range(0, 3) == 0);
            set_size(SizeW'($urandom_range(1, 8)), SizeW'($urandom_range(1, 8)));
            repeat ($urandom_range(1, 2)) send_random_image();
        end
        no_gaps = 1'b0;
        no_stalls = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        alpha_in = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = '0;
        cycle_count = 0;
        mismatch_count = 0;
        words_sent = 0;
        pixels_seen = 0;
        deepest_level = 0;
        no_gaps = 1'b0;
        no_stalls = 1'b0;
        width_reg = SizeW'(256);
        height_reg = SizeW'(256);
        for (int lv = 0; lv < MaxLevels; lv++)
        begin
            col_count[lv] = 0;
            row_count[lv] = 0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_wide_image();
        test_tall_image();
        test_random_images();

        release_input();
        wait_idle();
        $display("streamed %0d level-0 pixels, checked %0d mip pixels up to level %0d",
                 words_sent, pixels_seen, deepest_level);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
